[rtl/qte_pkg.sv]
// Shared types, constants and arithmetic helpers for the quaternion to Euler block.
package qte_pkg;

	// Input component width and CORDIC depth
	localparam int COMPONENT_BITS = 16;
	localparam int CORDIC_STAGES  = 16;

	// CORDIC vector width and angle width (Q.24 radians)
	localparam int CW = 38;
	localparam int ZW = 28;

	// Square root pipeline: one result bit per stage, plus the input register
	localparam int ISQ_W      = 64;
	localparam int ISQ_STAGES = 32;
	localparam int ISQ_TOP    = 62;
	localparam int LINE_LEN   = ISQ_STAGES + 1;

	// Decoupling queue depth
	localparam int FQ_DEPTH = 4;
	localparam int FQ_AW    = $clog2(FQ_DEPTH);

	localparam logic [15:0] THR_RESET = 16'd32702;

	localparam logic signed [ZW-1:0] ANG_PI      = 28'sd52707179;
	localparam logic signed [ZW-1:0] ANG_HALF_PI = 28'sd26353589;

	localparam logic signed [ZW-1:0] ATAN_LOW [8] = '{
		28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331,
		28'sd1047214, 28'sd524117, 28'sd262123, 28'sd131069
	};

	typedef enum logic [1:0] {
		POLE_NONE  = 2'd0,
		POLE_NORTH = 2'd1,
		POLE_SOUTH = 2'd2,
		POLE_ZERO  = 2'd3
	} pole_t;

	typedef struct packed {
		logic signed [COMPONENT_BITS-1:0] quat_w;
		logic signed [COMPONENT_BITS-1:0] quat_x;
		logic signed [COMPONENT_BITS-1:0] quat_y;
		logic signed [COMPONENT_BITS-1:0] quat_z;
	} quat_t;

	typedef struct packed {
		logic signed [15:0] heading_angle;
		logic signed [15:0] attitude_angle;
		logic signed [15:0] bank_angle;
		pole_t              pole_case;
	} euler_t;

	// Front results waiting for the square root
	typedef struct packed {
		logic signed [15:0]   w;
		logic signed [15:0]   x;
		logic                 zero;
		logic signed [32:0]   t;
		logic [49:0]          rhs;
		logic signed [CW-1:0] hy;
		logic signed [CW-1:0] hx;
		logic signed [CW-1:0] by;
		logic signed [CW-1:0] bx;
	} fline_t;

	// Classified item handed from front to back
	typedef struct packed {
		pole_t                kind;
		logic signed [CW-1:0] hy;
		logic signed [CW-1:0] hx;
		logic signed [CW-1:0] ay;
		logic signed [CW-1:0] ax;
		logic signed [CW-1:0] by;
		logic signed [CW-1:0] bx;
	} qent_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	// Bring a raw component to Q2.14 (floor on narrowing)
	function automatic logic signed [15:0] take_component(
		input logic signed [COMPONENT_BITS-1:0] raw);
		logic signed [47:0] e;
		e = 48'(raw);
		e = (e <<< 16) >>> COMPONENT_BITS;
		return e[15:0];
	endfunction

	// atan(2^-i) in Q.24
	function automatic logic signed [ZW-1:0] atan_entry(input int i);
		if (i < 8) begin
			return ATAN_LOW[i];
		end else if (i <= 24) begin
			return ZW'(1) <<< (24 - i);
		end
		return '0;
	endfunction

	// Trial bit of square root stage k
	function automatic logic [ISQ_W-1:0] isq_bit(input int k);
		return ISQ_W'(1) << (ISQ_TOP - 2 * k);
	endfunction

	// Q.24 to Q3.13 with rounding and saturation
	function automatic logic signed [15:0] to_q3_13(input logic signed [31:0] a);
		logic signed [31:0] r;
		r = (a + 32'sd1024) >>> 11;
		if (r > 32'sd32767) begin
			r = 32'sd32767;
		end else if (r < -32'sd32768) begin
			r = -32'sd32768;
		end
		return r[15:0];
	endfunction

endpackage

[rtl/qte_isqrt.sv]
// Pipelined floor square root, one result bit per stage.
module qte_isqrt import qte_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic [ISQ_W-1:0] v,
	output logic [31:0]      root
);

	logic [ISQ_W-1:0] rem_s  [0:ISQ_STAGES];
	logic [ISQ_W-1:0] root_s [0:ISQ_STAGES];

	// Advance the remainder and partial root one stage per cycle while en is high
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= v;
			root_s[0] <= '0;
			for (int k = 0; k < ISQ_STAGES; k++) begin
				if (rem_s[k] >= root_s[k] + isq_bit(k)) begin
					rem_s[k+1]  <= rem_s[k] - (root_s[k] + isq_bit(k));
					root_s[k+1] <= (root_s[k] >> 1) + isq_bit(k);
				end else begin
					rem_s[k+1]  <= rem_s[k];
					root_s[k+1] <= root_s[k] >> 1;
				end
			end
		end
	end

	assign root = root_s[ISQ_STAGES][31:0];

endmodule

[rtl/qte_front.sv]
// Front part: products, sums, pole test and square root, then classification.
module qte_front import qte_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       quat_valid,
	output logic       quat_stall,
	input  quat_t      quat,
	input  logic [15:0] thr,
	input  fifo_stat_t stat,
	output logic       push,
	output qent_t      push_data
);

	logic en;
	logic v_s1, v_s2, v_s3, v_s4;
	logic v_line_s [0:LINE_LEN-1];

	logic signed [15:0] w_s1, x_s1, y_s1, z_s1;
	logic signed [15:0] w_s2, x_s2;
	logic signed [31:0] sw_s2, sx_s2, sy_s2, sz_s2;
	logic signed [31:0] xy_s2, zw_s2, yw_s2, xz_s2, xw_s2, yz_s2;
	logic [33:0]        da_s2, db_s2, sa_s2, sb_s2;
	logic signed [15:0] w_s3, x_s3;
	logic [33:0]        unit_s3;
	logic signed [32:0] t_s3;
	logic signed [CW-1:0] hy_s3, hx_s3, by_s3, bx_s3;
	logic [31:0]        a4_s3, b4_s3;
	fline_t             f_s4;
	logic [ISQ_W-1:0]   ab_s4;
	fline_t             line_s [0:LINE_LEN-1];
	logic [31:0]        root;

	logic signed [16:0] dxy, dwz, pxy, pwz;
	logic signed [33:0] dxy2, dwz2, pxy2, pwz2;
	logic signed [35:0] unit_c, t_c, hy_c, hx_c, by_c, bx_c;
	logic [34:0]        a_c, b_c;
	fline_t             f_c;
	fline_t             fl;
	logic signed [51:0] lhs52, rhs52;

	// Hold every stage while the last one waits on a full queue
	assign en         = !(v_line_s[LINE_LEN-1] && stat.full);
	assign quat_stall = !en;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			for (int i = 0; i < LINE_LEN; i++) begin
				v_line_s[i] <= 1'b0;
			end
		end else if (en) begin
			v_s1 <= quat_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_line_s[0] <= v_s4;
			for (int i = 1; i < LINE_LEN; i++) begin
				v_line_s[i] <= v_line_s[i-1];
			end
		end
	end

	// Differences and sums for the attitude cosine
	always_comb begin
		dxy  = 17'(x_s1) - 17'(y_s1);
		dwz  = 17'(w_s1) - 17'(z_s1);
		pxy  = 17'(x_s1) + 17'(y_s1);
		pwz  = 17'(w_s1) + 17'(z_s1);
		dxy2 = dxy * dxy;
		dwz2 = dwz * dwz;
		pxy2 = pxy * pxy;
		pwz2 = pwz * pwz;
	end

	// Sums of products
	always_comb begin
		unit_c = 36'(sw_s2) + 36'(sx_s2) + 36'(sy_s2) + 36'(sz_s2);
		t_c    = 36'(xy_s2) + 36'(zw_s2);
		hy_c   = (36'(yw_s2) - 36'(xz_s2)) <<< 1;
		hx_c   = 36'(sw_s2) + 36'(sx_s2) - 36'(sy_s2) - 36'(sz_s2);
		by_c   = (36'(xw_s2) - 36'(yz_s2)) <<< 1;
		bx_c   = 36'(sw_s2) - 36'(sx_s2) + 36'(sy_s2) - 36'(sz_s2);
		a_c    = 35'(da_s2) + 35'(db_s2);
		b_c    = 35'(sa_s2) + 35'(sb_s2);
	end

	// Pole test operands
	always_comb begin
		f_c      = '0;
		f_c.w    = w_s3;
		f_c.x    = x_s3;
		f_c.zero = (unit_s3 == '0);
		f_c.t    = t_s3;
		f_c.rhs  = {34'd0, thr} * {16'd0, unit_s3};
		f_c.hy   = hy_s3;
		f_c.hx   = hx_s3;
		f_c.by   = by_s3;
		f_c.bx   = bx_s3;
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (en) begin
			w_s1  <= take_component(quat.quat_w);
			x_s1  <= take_component(quat.quat_x);
			y_s1  <= take_component(quat.quat_y);
			z_s1  <= take_component(quat.quat_z);
			w_s2  <= w_s1;
			x_s2  <= x_s1;
			sw_s2 <= w_s1 * w_s1;
			sx_s2 <= x_s1 * x_s1;
			sy_s2 <= y_s1 * y_s1;
			sz_s2 <= z_s1 * z_s1;
			xy_s2 <= x_s1 * y_s1;
			zw_s2 <= z_s1 * w_s1;
			yw_s2 <= y_s1 * w_s1;
			xz_s2 <= x_s1 * z_s1;
			xw_s2 <= x_s1 * w_s1;
			yz_s2 <= y_s1 * z_s1;
			da_s2 <= dxy2;
			db_s2 <= dwz2;
			sa_s2 <= pxy2;
			sb_s2 <= pwz2;
			w_s3    <= w_s2;
			x_s3    <= x_s2;
			unit_s3 <= unit_c[33:0];
			t_s3    <= t_c[32:0];
			hy_s3   <= CW'(hy_c);
			hx_s3   <= CW'(hx_c);
			by_s3   <= CW'(by_c);
			bx_s3   <= CW'(bx_c);
			a4_s3   <= a_c[33:2];
			b4_s3   <= b_c[33:2];
			f_s4  <= f_c;
			ab_s4 <= a4_s3 * b4_s3;
			line_s[0] <= f_s4;
			for (int i = 1; i < LINE_LEN; i++) begin
				line_s[i] <= line_s[i-1];
			end
		end
	end

	qte_isqrt u_isqrt (
		.clk  (clk),
		.en   (en),
		.v    (ab_s4),
		.root (root)
	);

	// Classify and build the queue entry
	always_comb begin
		fl    = line_s[LINE_LEN-1];
		lhs52 = {{3{fl.t[32]}}, fl.t, 16'd0};
		rhs52 = {2'b00, fl.rhs};
		push_data      = '0;
		push_data.hy   = fl.hy;
		push_data.hx   = fl.hx;
		push_data.ay   = CW'(fl.t >>> 1);
		push_data.ax   = CW'({1'b0, root});
		push_data.by   = fl.by;
		push_data.bx   = fl.bx;
		if (fl.zero) begin
			push_data.kind = POLE_ZERO;
		end else if (lhs52 > rhs52) begin
			push_data.kind = POLE_NORTH;
		end else if (lhs52 < -rhs52) begin
			push_data.kind = POLE_SOUTH;
		end else begin
			push_data.kind = POLE_NONE;
		end
		if (push_data.kind == POLE_NORTH || push_data.kind == POLE_SOUTH) begin
			push_data.hy = CW'(fl.x);
			push_data.hx = CW'(fl.w);
		end
	end

	assign push = en && v_line_s[LINE_LEN-1];

endmodule

[rtl/qte_fifo.sv]
// Short register queue between front and back.
module qte_fifo import qte_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  qent_t      din,
	input  logic       pop,
	output qent_t      dout,
	output fifo_stat_t stat
);

	qent_t            entries_q [0:FQ_DEPTH-1];
	logic [FQ_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FQ_AW:0]   cnt_q;

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Store a beat
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= din;
		end
	end

	assign dout       = entries_q[rd_ptr_q];
	assign stat.full  = (cnt_q == (FQ_AW+1)'(FQ_DEPTH));
	assign stat.empty = (cnt_q == '0);

endmodule

[rtl/qte_cordic.sv]
// One CORDIC vectoring lane: atan2(y, x) in Q.24, one stage per cycle while en is high.
module qte_cordic import qte_pkg::*; (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [CW-1:0] y_in,
	input  logic signed [CW-1:0] x_in,
	output logic signed [ZW-1:0] z_out
);

	logic signed [CW-1:0] x_s [0:CORDIC_STAGES];
	logic signed [CW-1:0] y_s [0:CORDIC_STAGES];
	logic signed [ZW-1:0] z_s [0:CORDIC_STAGES];
	logic                 zero_s [0:CORDIC_STAGES];

	always_ff @(posedge clk) begin
		if (en) begin
			// Fold the left half plane onto the right
			zero_s[0] <= (x_in == '0) && (y_in == '0);
			if (x_in < 0) begin
				x_s[0] <= -x_in;
				y_s[0] <= -y_in;
				z_s[0] <= (y_in >= 0) ? ANG_PI : -ANG_PI;
			end else begin
				x_s[0] <= x_in;
				y_s[0] <= y_in;
				z_s[0] <= '0;
			end
			// Rotate toward the x axis
			for (int i = 0; i < CORDIC_STAGES; i++) begin
				zero_s[i+1] <= zero_s[i];
				if (y_s[i] > 0) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + atan_entry(i);
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - atan_entry(i);
				end
			end
		end
	end

	assign z_out = zero_s[CORDIC_STAGES] ? '0 : z_s[CORDIC_STAGES];

endmodule

[rtl/qte_back.sv]
// Back part: three CORDIC lanes and the output register.
module qte_back import qte_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  qent_t      head,
	input  fifo_stat_t stat,
	output logic       pop,
	output logic       euler_valid,
	input  logic       euler_stall,
	output euler_t     euler
);

	logic en;
	logic vb_s [0:CORDIC_STAGES];
	pole_t kind_s [0:CORDIC_STAGES];
	logic euler_valid_q;
	euler_t euler_q, euler_c;
	logic signed [ZW-1:0] hz, az, bz;
	logic signed [31:0] h2;

	// Hold all stages while the result waits
	assign en  = !euler_valid_q || !euler_stall;
	assign pop = en && !stat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= CORDIC_STAGES; i++) begin
				vb_s[i] <= 1'b0;
			end
			euler_valid_q <= 1'b0;
		end else if (en) begin
			vb_s[0] <= !stat.empty;
			for (int i = 0; i < CORDIC_STAGES; i++) begin
				vb_s[i+1] <= vb_s[i];
			end
			euler_valid_q <= vb_s[CORDIC_STAGES];
		end
	end

	// Carry the pole class beside the lanes
	always_ff @(posedge clk) begin
		if (en) begin
			kind_s[0] <= head.kind;
			for (int i = 0; i < CORDIC_STAGES; i++) begin
				kind_s[i+1] <= kind_s[i];
			end
			euler_q <= euler_c;
		end
	end

	qte_cordic u_head (.clk(clk), .en(en), .y_in(head.hy), .x_in(head.hx), .z_out(hz));
	qte_cordic u_att  (.clk(clk), .en(en), .y_in(head.ay), .x_in(head.ax), .z_out(az));
	qte_cordic u_bank (.clk(clk), .en(en), .y_in(head.by), .x_in(head.bx), .z_out(bz));

	// Format the angles per pole class
	always_comb begin
		h2 = 32'(hz) <<< 1;
		euler_c.pole_case = kind_s[CORDIC_STAGES];
		case (kind_s[CORDIC_STAGES])
			POLE_NORTH: begin
				euler_c.heading_angle  = to_q3_13(h2);
				euler_c.attitude_angle = to_q3_13(32'(ANG_HALF_PI));
				euler_c.bank_angle     = '0;
			end
			POLE_SOUTH: begin
				euler_c.heading_angle  = to_q3_13(-h2);
				euler_c.attitude_angle = to_q3_13(-32'(ANG_HALF_PI));
				euler_c.bank_angle     = '0;
			end
			POLE_NONE: begin
				euler_c.heading_angle  = to_q3_13(32'(hz));
				euler_c.attitude_angle = to_q3_13(32'(az));
				euler_c.bank_angle     = to_q3_13(32'(bz));
			end
			default: begin
				euler_c.heading_angle  = '0;
				euler_c.attitude_angle = '0;
				euler_c.bank_angle     = '0;
			end
		endcase
	end

	assign euler_valid = euler_valid_q;
	assign euler       = euler_q;

endmodule

[rtl/quaternion_to_euler_top.sv]
// Top level of the quaternion to Euler angle converter.
//
// Input channel quat (quat_valid, quat_stall, quat): one quaternion per beat,
// accepted when quat_valid is high and quat_stall low. Output channel euler
// (euler_valid, euler_stall, euler): heading, attitude and bank in Q3.13
// radians plus the pole class, taken when euler_valid is high and
// euler_stall low. cfg_valid/cfg_ready/cfg_data write pole_threshold;
// cfg_ready is always high.
// Throughput: one quaternion per cycle while quat_stall is low. Path from
// acceptance to euler_valid with an empty queue: 4 product/sum stages, 33 square
// root stages (input register plus one per root bit), the queue register,
// 17 CORDIC stages (fold plus one per iteration) and the output register.
// A four-entry queue separates front and back. When the receiver stalls, the
// back pipeline holds; the front keeps filling the queue and raises
// quat_stall once the queue is full and its last stage is loaded.
// Reset clears all valid bits and the queue and loads pole_threshold = 0.499.
module quaternion_to_euler_top import qte_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        quat_valid,
	output logic        quat_stall,
	input  quat_t       quat,
	output logic        euler_valid,
	input  logic        euler_stall,
	output euler_t      euler,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	logic [15:0] thr_q;
	logic        push, pop;
	qent_t       push_data, head;
	fifo_stat_t  stat;

	// Threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			thr_q <= cfg_data;
		end
	end

	assign cfg_ready = 1'b1;

	qte_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.quat_valid (quat_valid),
		.quat_stall (quat_stall),
		.quat       (quat),
		.thr        (thr_q),
		.stat       (stat),
		.push       (push),
		.push_data  (push_data)
	);

	qte_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (push_data),
		.pop    (pop),
		.dout   (head),
		.stat   (stat)
	);

	qte_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.stat        (stat),
		.pop         (pop),
		.euler_valid (euler_valid),
		.euler_stall (euler_stall),
		.euler       (euler)
	);

endmodule

[rtl/qte_checker.sv]
// Port-level assertions for the quaternion to Euler block, bound to the top level.
module qte_checker import qte_pkg::*; (
	input logic   clk,
	input logic   arst_n,
	input logic   euler_valid,
	input logic   euler_stall,
	input euler_t euler
);

	// Hold a stalled result beat
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		euler_valid && euler_stall |=> euler_valid && $stable(euler))
		else $error("stalled result changed");

	// Zero quaternion gives zero angles
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		euler_valid && euler.pole_case == POLE_ZERO |->
		euler.heading_angle == 16'sd0 && euler.attitude_angle == 16'sd0 &&
		euler.bank_angle == 16'sd0)
		else $error("zero quaternion with nonzero angles");

	// North pole: attitude +pi/2, bank zero
	a_north: assert property (@(posedge clk) disable iff (!arst_n)
		euler_valid && euler.pole_case == POLE_NORTH |->
		euler.attitude_angle == 16'sd12868 && euler.bank_angle == 16'sd0)
		else $error("north pole angles wrong");

	// South pole: attitude -pi/2, bank zero
	a_south: assert property (@(posedge clk) disable iff (!arst_n)
		euler_valid && euler.pole_case == POLE_SOUTH |->
		euler.attitude_angle == -16'sd12868 && euler.bank_angle == 16'sd0)
		else $error("south pole angles wrong");

endmodule

bind quaternion_to_euler_top qte_checker u_qte_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.euler_valid (euler_valid),
	.euler_stall (euler_stall),
	.euler       (euler)
);
